>>> hw/rtl/rgb2hsl_pkg.sv
// ----------------------------------------------------------------------------
// rgb2hsl_pkg
// Shared constants for the RGB to HSL pixel converter.
// ----------------------------------------------------------------------------
package rgb2hsl_pkg;

    // default channel width
    localparam int DEF_COLOR_BITS = 8;

    // fractional bits of hue and saturation
    localparam int FRAC_BITS = 16;

    // largest fraction, used when saturation reaches 1.0
    localparam logic [FRAC_BITS-1:0] FRAC_MAX = '1;

endpackage

>>> hw/rtl/rgb_to_hsl_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_top
// RGB to HSL pixel converter, fixed point, one pixel per clock while hsl_ready is high.
// ----------------------------------------------------------------------------
// Usage:
//   rgb channel: a pixel request (red_in, green_in, blue_in) is taken at a
//   clock edge with rgb_valid and rgb_ready high.
//   hsl channel: a result request (hue_out, saturation_out, lightness_out)
//   is handed over at an edge with hsl_valid and hsl_ready high.
//   hue_out and saturation_out are 16-bit fractions, lightness_out is
//   max + min of the channels.
//   The path from accept to hsl_valid runs through two front stages
//   (max/min, then chroma and divisors), 16 divider stages that each
//   settle one quotient bit of hue and of saturation, and the output
//   register.
//   Throughput is one pixel per clock while hsl_ready stays high; each
//   stage loads when it is empty or its content moves on, so a stalled
//   receiver holds only the full stages and bubbles are squeezed out.
//   Reset clears all stage valid bits; rgb_ready is high right after it.
//   rgb_ready is high whenever the output register is empty or hsl_ready
//   is high.
// ----------------------------------------------------------------------------
module rgb_to_hsl_top #(
    parameter int COLOR_BITS = rgb2hsl_pkg::DEF_COLOR_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rgb_valid,
    output logic                              rgb_ready,
    input  logic [COLOR_BITS-1:0]             red_in,
    input  logic [COLOR_BITS-1:0]             green_in,
    input  logic [COLOR_BITS-1:0]             blue_in,
    output logic                              hsl_valid,
    input  logic                              hsl_ready,
    output logic [rgb2hsl_pkg::FRAC_BITS-1:0] hue_out,
    output logic [rgb2hsl_pkg::FRAC_BITS-1:0] saturation_out,
    output logic [COLOR_BITS:0]               lightness_out
);
    import rgb2hsl_pkg::*;

    localparam int CW = COLOR_BITS;
    localparam int HW = COLOR_BITS + 3;

    // front to divider
    logic          f_valid;
    logic          f_ready;
    logic          f_grey;
    logic          f_full;
    logic [CW:0]   f_light;
    logic [CW-1:0] f_sat_num;
    logic [CW-1:0] f_sat_den;
    logic [HW-1:0] f_hue_num;
    logic [HW-1:0] f_hue_den;

    // divider to output register
    logic                 d_valid;
    logic                 d_ready;
    logic                 d_grey;
    logic                 d_full;
    logic [CW:0]          d_light;
    logic [FRAC_BITS-1:0] d_sat_q;
    logic [FRAC_BITS-1:0] d_hue_q;

    // output register
    logic                 hsl_valid_reg;
    logic [FRAC_BITS-1:0] hue_reg;
    logic [FRAC_BITS-1:0] sat_reg;
    logic [CW:0]          light_reg;
    logic [FRAC_BITS-1:0] hue_next;
    logic [FRAC_BITS-1:0] sat_next;

    rgb2hsl_front #(
        .COLOR_BITS (COLOR_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rgb_valid),
        .in_ready  (rgb_ready),
        .red       (red_in),
        .green     (green_in),
        .blue      (blue_in),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .grey      (f_grey),
        .sat_full  (f_full),
        .light     (f_light),
        .sat_num   (f_sat_num),
        .sat_den   (f_sat_den),
        .hue_num   (f_hue_num),
        .hue_den   (f_hue_den)
    );

    rgb2hsl_div #(
        .COLOR_BITS (COLOR_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_grey   (f_grey),
        .in_full   (f_full),
        .in_light  (f_light),
        .sat_num   (f_sat_num),
        .sat_den   (f_sat_den),
        .hue_num   (f_hue_num),
        .hue_den   (f_hue_den),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_grey  (d_grey),
        .out_full  (d_full),
        .out_light (d_light),
        .sat_q     (d_sat_q),
        .hue_q     (d_hue_q)
    );

    assign d_ready = !hsl_valid_reg || hsl_ready;

    // grey pixels give zero hue and saturation, saturation of one clamps
    always_comb
    begin
        priority if (d_grey)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else if (d_full)
        begin
            hue_next = d_hue_q;
            sat_next = FRAC_MAX;
        end
        else
        begin
            hue_next = d_hue_q;
            sat_next = d_sat_q;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsl_valid_reg <= 1'b0;
        end
        else if (d_ready)
        begin
            hsl_valid_reg <= d_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (d_ready)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            light_reg <= d_light;
        end
    end

    assign hsl_valid      = hsl_valid_reg;
    assign hue_out        = hue_reg;
    assign saturation_out = sat_reg;
    assign lightness_out  = light_reg;

endmodule

>>> hw/rtl/rgb2hsl_front.sv
// ----------------------------------------------------------------------------
// rgb2hsl_front
// Two pipeline stages: max/min search and sector pick, then lightness,
// chroma and the numerators and divisors for hue and saturation.
// ----------------------------------------------------------------------------
module rgb2hsl_front #(
    parameter int COLOR_BITS = rgb2hsl_pkg::DEF_COLOR_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COLOR_BITS-1:0] red,
    input  logic [COLOR_BITS-1:0] green,
    input  logic [COLOR_BITS-1:0] blue,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  grey,
    output logic                  sat_full,
    output logic [COLOR_BITS:0]   light,
    output logic [COLOR_BITS-1:0] sat_num,
    output logic [COLOR_BITS-1:0] sat_den,
    output logic [COLOR_BITS+2:0] hue_num,
    output logic [COLOR_BITS+2:0] hue_den
);
    import rgb2hsl_pkg::*;

    localparam int CW = COLOR_BITS;
    localparam int HW = COLOR_BITS + 3;
    localparam logic [CW:0] FULL     = {1'b0, {CW{1'b1}}};
    localparam logic [CW:0] TWO_FULL = {{CW{1'b1}}, 1'b0};

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_RED_WRAP,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // stage a registers
    logic          a_valid_reg;
    logic [CW-1:0] a_hi_reg;
    logic [CW-1:0] a_lo_reg;
    logic [CW-1:0] a_r_reg;
    logic [CW-1:0] a_g_reg;
    logic [CW-1:0] a_b_reg;
    sector_t       a_sec_reg;

    logic [CW-1:0] a_hi_next;
    logic [CW-1:0] a_lo_next;
    sector_t       a_sec_next;

    // stage b registers
    logic          b_valid_reg;
    logic          b_grey_reg;
    logic          b_full_reg;
    logic [CW:0]   b_light_reg;
    logic [CW-1:0] b_sat_num_reg;
    logic [CW-1:0] b_sat_den_reg;
    logic [HW-1:0] b_hue_num_reg;
    logic [HW-1:0] b_hue_den_reg;

    logic [CW:0]   b_sum;
    logic [CW:0]   b_mirror;
    logic [CW-1:0] b_chroma;
    logic [HW-1:0] b_chroma_w;
    logic [CW-1:0] b_sat_den_next;
    logic [HW-1:0] b_hue_den_next;
    logic [HW-1:0] b_hue_num_next;

    logic a_load;
    logic b_load;

    // stage enables: a stage loads when empty or when its content moves on
    assign b_load   = !b_valid_reg || out_ready;
    assign a_load   = !a_valid_reg || b_load;
    assign in_ready = a_load;

    // max, min and the sector of the largest channel, ties to red then green
    always_comb
    begin
        a_hi_next = red;
        a_lo_next = red;
        if (green > a_hi_next)
        begin
            a_hi_next = green;
        end
        if (blue > a_hi_next)
        begin
            a_hi_next = blue;
        end
        if (green < a_lo_next)
        begin
            a_lo_next = green;
        end
        if (blue < a_lo_next)
        begin
            a_lo_next = blue;
        end
        priority if (a_hi_next == red)
        begin
            a_sec_next = (green < blue) ? SEC_RED_WRAP : SEC_RED;
        end
        else if (a_hi_next == green)
        begin
            a_sec_next = SEC_GREEN;
        end
        else
        begin
            a_sec_next = SEC_BLUE;
        end
    end

    // stage a valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_load)
        begin
            a_valid_reg <= in_valid;
        end
    end

    // stage a payload
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_hi_reg  <= a_hi_next;
            a_lo_reg  <= a_lo_next;
            a_r_reg   <= red;
            a_g_reg   <= green;
            a_b_reg   <= blue;
            a_sec_reg <= a_sec_next;
        end
    end

    // lightness, chroma, saturation and hue divisors
    always_comb
    begin
        b_sum      = {1'b0, a_hi_reg} + {1'b0, a_lo_reg};
        b_chroma   = a_hi_reg - a_lo_reg;
        b_chroma_w = HW'(b_chroma);
        b_mirror   = TWO_FULL - b_sum;
        if (b_sum <= FULL)
        begin
            b_sat_den_next = b_sum[CW-1:0];
        end
        else
        begin
            b_sat_den_next = b_mirror[CW-1:0];
        end
        b_hue_den_next = (b_chroma_w << 2) + (b_chroma_w << 1);
    end

    // hue numerator in units of one sixth turn per chroma, wraps modulo 2^HW
    always_comb
    begin
        unique case (a_sec_reg)
            SEC_RED:
            begin
                b_hue_num_next = HW'(a_g_reg) - HW'(a_b_reg);
            end
            SEC_RED_WRAP:
            begin
                b_hue_num_next = b_hue_den_next - (HW'(a_b_reg) - HW'(a_g_reg));
            end
            SEC_GREEN:
            begin
                b_hue_num_next = (b_chroma_w << 1) + HW'(a_b_reg) - HW'(a_r_reg);
            end
            SEC_BLUE:
            begin
                b_hue_num_next = (b_chroma_w << 2) + HW'(a_r_reg) - HW'(a_g_reg);
            end
            default:
            begin
                b_hue_num_next = '0;
            end
        endcase
    end

    // stage b valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_load)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    // stage b payload
    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_grey_reg    <= (b_chroma == '0);
            b_full_reg    <= (b_chroma == b_sat_den_next);
            b_light_reg   <= b_sum;
            b_sat_num_reg <= b_chroma;
            b_sat_den_reg <= b_sat_den_next;
            b_hue_num_reg <= b_hue_num_next;
            b_hue_den_reg <= b_hue_den_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign grey      = b_grey_reg;
    assign sat_full  = b_full_reg;
    assign light     = b_light_reg;
    assign sat_num   = b_sat_num_reg;
    assign sat_den   = b_sat_den_reg;
    assign hue_num   = b_hue_num_reg;
    assign hue_den   = b_hue_den_reg;

endmodule

>>> hw/rtl/rgb2hsl_div.sv
// ----------------------------------------------------------------------------
// rgb2hsl_div
// Pipelined restoring divider, one quotient bit per stage, two lanes in
// lockstep: saturation (chroma over its divisor) and hue (numerator over
// six times chroma). Dividends do not exceed their divisors; equality
// only comes with the grey or full flag set, and the top level then overrides it.
// ----------------------------------------------------------------------------
module rgb2hsl_div #(
    parameter int COLOR_BITS = rgb2hsl_pkg::DEF_COLOR_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_grey,
    input  logic                                in_full,
    input  logic [COLOR_BITS:0]                 in_light,
    input  logic [COLOR_BITS-1:0]               sat_num,
    input  logic [COLOR_BITS-1:0]               sat_den,
    input  logic [COLOR_BITS+2:0]               hue_num,
    input  logic [COLOR_BITS+2:0]               hue_den,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_grey,
    output logic                                out_full,
    output logic [COLOR_BITS:0]                 out_light,
    output logic [rgb2hsl_pkg::FRAC_BITS-1:0]   sat_q,
    output logic [rgb2hsl_pkg::FRAC_BITS-1:0]   hue_q
);
    import rgb2hsl_pkg::*;

    localparam int CW = COLOR_BITS;
    localparam int HW = COLOR_BITS + 3;
    localparam int NS = FRAC_BITS;

    // per stage registers
    logic           v_reg     [NS];
    logic           grey_reg  [NS];
    logic           full_reg  [NS];
    logic [CW:0]    light_reg [NS];
    logic [CW-1:0]  rs_reg    [NS];
    logic [CW-1:0]  ds_reg    [NS];
    logic [HW-1:0]  rh_reg    [NS];
    logic [HW-1:0]  dh_reg    [NS];
    logic [NS-1:0]  qs_reg    [NS];
    logic [NS-1:0]  qh_reg    [NS];

    logic [NS:0] ld;

    // load enables ripple back from the consumer
    always_comb
    begin
        ld[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign in_ready = ld[0];

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic          v_in;
        logic          grey_in;
        logic          full_in;
        logic [CW:0]   light_in;
        logic [CW-1:0] rs_in;
        logic [CW-1:0] ds_in;
        logic [HW-1:0] rh_in;
        logic [HW-1:0] dh_in;
        logic [NS-1:0] qs_in;
        logic [NS-1:0] qh_in;

        logic [CW:0]   rs_sh;
        logic [CW:0]   rs_diff;
        logic [HW:0]   rh_sh;
        logic [HW:0]   rh_diff;
        logic          s_ge;
        logic          h_ge;
        logic [CW-1:0] rs_next;
        logic [HW-1:0] rh_next;

        // stage input: module ports or the previous stage
        if (i == 0)
        begin : g_first
            assign v_in     = in_valid;
            assign grey_in  = in_grey;
            assign full_in  = in_full;
            assign light_in = in_light;
            assign rs_in    = sat_num;
            assign ds_in    = sat_den;
            assign rh_in    = hue_num;
            assign dh_in    = hue_den;
            assign qs_in    = '0;
            assign qh_in    = '0;
        end
        else
        begin : g_next
            assign v_in     = v_reg[i-1];
            assign grey_in  = grey_reg[i-1];
            assign full_in  = full_reg[i-1];
            assign light_in = light_reg[i-1];
            assign rs_in    = rs_reg[i-1];
            assign ds_in    = ds_reg[i-1];
            assign rh_in    = rh_reg[i-1];
            assign dh_in    = dh_reg[i-1];
            assign qs_in    = qs_reg[i-1];
            assign qh_in    = qh_reg[i-1];
        end

        // one restoring step per lane
        always_comb
        begin
            rs_sh   = {rs_in, 1'b0};
            rs_diff = rs_sh - {1'b0, ds_in};
            s_ge    = (rs_sh >= {1'b0, ds_in});
            rs_next = s_ge ? rs_diff[CW-1:0] : rs_sh[CW-1:0];
            rh_sh   = {rh_in, 1'b0};
            rh_diff = rh_sh - {1'b0, dh_in};
            h_ge    = (rh_sh >= {1'b0, dh_in});
            rh_next = h_ge ? rh_diff[HW-1:0] : rh_sh[HW-1:0];
        end

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (ld[i])
            begin
                v_reg[i] <= v_in;
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (ld[i])
            begin
                grey_reg[i]  <= grey_in;
                full_reg[i]  <= full_in;
                light_reg[i] <= light_in;
                rs_reg[i]    <= rs_next;
                ds_reg[i]    <= ds_in;
                rh_reg[i]    <= rh_next;
                dh_reg[i]    <= dh_in;
                qs_reg[i]    <= {qs_in[NS-2:0], s_ge};
                qh_reg[i]    <= {qh_in[NS-2:0], h_ge};
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_grey  = grey_reg[NS-1];
    assign out_full  = full_reg[NS-1];
    assign out_light = light_reg[NS-1];
    assign sat_q     = qs_reg[NS-1];
    assign hue_q     = qh_reg[NS-1];

endmodule

>>> hw/rtl/rgb2hsl_chk.sv
// ----------------------------------------------------------------------------
// rgb2hsl_chk
// Port level checks for the RGB to HSL converter, bound to the top level.
// ----------------------------------------------------------------------------
module rgb2hsl_chk #(
    parameter int COLOR_BITS = rgb2hsl_pkg::DEF_COLOR_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rgb_ready,
    input  logic                              hsl_valid,
    input  logic                              hsl_ready,
    input  logic [rgb2hsl_pkg::FRAC_BITS-1:0] hue_out,
    input  logic [rgb2hsl_pkg::FRAC_BITS-1:0] saturation_out,
    input  logic [COLOR_BITS:0]               lightness_out
);
    import rgb2hsl_pkg::*;

    localparam logic [COLOR_BITS:0] TWO_FULL = {{COLOR_BITS{1'b1}}, 1'b0};

    // a stalled result holds its value
    a_hold_stalled : assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && !hsl_ready |=> hsl_valid && $stable(hue_out)
            && $stable(saturation_out) && $stable(lightness_out))
        else $error("stalled result changed");

    // the pipeline never blocks requests while the output side can move
    a_ready_flow : assert property (@(posedge clk) disable iff (!rst_n)
        !hsl_valid || hsl_ready |-> rgb_ready)
        else $error("input blocked while output can drain");

    // zero saturation only for grey pixels, which have zero hue
    a_grey_hue : assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && saturation_out == '0 |-> hue_out == '0)
        else $error("zero saturation with nonzero hue");

    // lightness cannot exceed twice the full scale
    a_light_range : assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid |-> lightness_out <= TWO_FULL)
        else $error("lightness out of range");

endmodule

bind rgb_to_hsl_top rgb2hsl_chk #(
    .COLOR_BITS (COLOR_BITS)
) u_rgb2hsl_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .rgb_ready      (rgb_ready),
    .hsl_valid      (hsl_valid),
    .hsl_ready      (hsl_ready),
    .hue_out        (hue_out),
    .saturation_out (saturation_out),
    .lightness_out  (lightness_out)
);
